>>> rtl/lkv_pkg.sv
// lkv_pkg: shared constants, entry layout, sequencer states and ram request struct
// for the lru key/value cache; no dependencies
package lkv_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_WIDTH = 32;

    localparam int KEY_W   = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W   = IDX_W;
    localparam int COUNT_W = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // register index, taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [AGE_W-1:0] age;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT,
        ST_UPDATE
    } state_t;

endpackage

>>> rtl/lkv_entry_ram.sv
// lkv_entry_ram: entry store holding key, value and recency rank per slot
// one write port, one read port with registered read data; uses lkv_pkg
module lkv_entry_ram
    import lkv_pkg::*;
(
    input  logic     aclk,
    input  ram_req_t req,
    output entry_t   rdata
);

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lkv_apb_regs.sv
// lkv_apb_regs: apb register file holding cache_capacity and producing its clamped form
// depends on lkv_pkg
module lkv_apb_regs
    import lkv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [COUNT_W-1:0] eff_cap
);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             sel_cap;

    assign pready  = 1'b1;
    assign sel_cap = (paddr[PADDR_W-1:2] == REG_CAPACITY);

    always_comb begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && pready && sel_cap) begin
            cap_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else begin
            cap_reg <= cap_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (sel_cap) begin
            prdata = PDATA_W'(cap_reg);
        end
    end

    // zero acts as one, anything above the slot count saturates
    always_comb begin
        if (int'(cap_reg) > ENTRIES) begin
            eff_cap = COUNT_W'(ENTRIES);
        end else if (cap_reg == '0) begin
            eff_cap = COUNT_W'(1);
        end else begin
            eff_cap = COUNT_W'(cap_reg);
        end
    end

endmodule

>>> rtl/lkv_engine.sv
// lkv_engine: request sequencer; search sweep over the entry ram, then for a set
// or get hit a read-modify-write sweep that reorders recency; depends on lkv_pkg
module lkv_engine
    import lkv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [31:0]        s_key,
    input  logic [31:0]        s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [31:0]        m_read_value,
    input  logic [COUNT_W-1:0] eff_cap,
    output ram_req_t           ram_req,
    input  entry_t             ram_rdata
);

    state_t             state_reg, state_next;
    logic               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               pend_reg, pend_next;
    logic [IDX_W-1:0]   pidx_reg, pidx_next;

    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [AGE_W-1:0]   hit_age_reg, hit_age_next;
    logic [VAL_W-1:0]   hit_val_reg, hit_val_next;
    logic               vic_reg, vic_next;
    logic [IDX_W-1:0]   vic_idx_reg, vic_idx_next;
    logic [AGE_W-1:0]   vic_age_reg, vic_age_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic [IDX_W-1:0]   tgt_idx_reg, tgt_idx_next;
    logic [AGE_W-1:0]   limit_reg, limit_next;
    logic               all_reg, all_next;
    logic               insert_reg, insert_next;
    logic [VAL_W-1:0]   tval_reg, tval_next;

    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_found_reg, m_found_next;
    logic [31:0]        m_value_reg, m_value_next;

    logic               sweep_done;
    entry_t             wb_entry;

    assign m_valid      = m_valid_reg;
    assign m_found      = m_found_reg;
    assign m_read_value = m_value_reg;
    assign sweep_done   = !pend_reg && (cnt_reg == COUNT_W'(ENTRIES));

    // write-back value for the slot whose read returns this cycle
    always_comb begin
        wb_entry = ram_rdata;
        if (pidx_reg == tgt_idx_reg) begin
            wb_entry.key   = key_reg;
            wb_entry.value = tval_reg;
            wb_entry.age   = '0;
        end else if (valid_reg[pidx_reg] && (all_reg || ram_rdata.age < limit_reg)) begin
            wb_entry.age = ram_rdata.age + AGE_W'(1);
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_age_next  = hit_age_reg;
        hit_val_next  = hit_val_reg;
        vic_next      = vic_reg;
        vic_idx_next  = vic_idx_reg;
        vic_age_next  = vic_age_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        tgt_idx_next  = tgt_idx_reg;
        limit_next    = limit_reg;
        all_next      = all_reg;
        insert_next   = insert_reg;
        tval_next     = tval_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_found_next  = m_found_reg;
        m_value_next  = m_value_reg;
        s_ready       = 1'b0;
        ram_req       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_command;
                    key_next   = s_key[KEY_W-1:0];
                    val_next   = s_value;
                    cnt_next   = '0;
                    hit_next   = 1'b0;
                    vic_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH: begin
                if (cnt_reg != COUNT_W'(ENTRIES)) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = cnt_reg[IDX_W-1:0];
                    pidx_next     = cnt_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    cnt_next      = cnt_reg + COUNT_W'(1);
                end
                if (pend_reg) begin
                    if (valid_reg[pidx_reg]) begin
                        if (!hit_reg && ram_rdata.key == key_reg) begin
                            hit_next     = 1'b1;
                            hit_idx_next = pidx_reg;
                            hit_age_next = ram_rdata.age;
                            hit_val_next = ram_rdata.value;
                        end
                        if (!vic_reg || ram_rdata.age > vic_age_reg) begin
                            vic_next     = 1'b1;
                            vic_idx_next = pidx_reg;
                            vic_age_next = ram_rdata.age;
                        end
                    end else if (!free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                end
                if (sweep_done) begin
                    cnt_next    = '0;
                    all_next    = 1'b0;
                    insert_next = 1'b0;
                    tval_next   = val_reg;
                    priority if (hit_reg) begin
                        tgt_idx_next = hit_idx_reg;
                        limit_next   = hit_age_reg;
                        if (cmd_reg == CMD_GET) begin
                            tval_next = hit_val_reg;
                        end
                        state_next = (cmd_reg == CMD_GET) ? ST_RESULT : ST_UPDATE;
                    end else if (cmd_reg == CMD_GET) begin
                        state_next = ST_RESULT;
                    end else if (count_reg >= eff_cap && vic_reg) begin
                        // full: reuse the least recent slot
                        tgt_idx_next = vic_idx_reg;
                        limit_next   = vic_age_reg;
                        state_next   = ST_UPDATE;
                    end else if (free_reg) begin
                        tgt_idx_next = free_idx_reg;
                        all_next     = 1'b1;
                        insert_next  = 1'b1;
                        state_next   = ST_UPDATE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = hit_reg;
                    m_value_next = hit_reg ? hit_val_reg : '0;
                    state_next   = hit_reg ? ST_UPDATE : ST_IDLE;
                end
            end

            ST_UPDATE: begin
                if (cnt_reg != COUNT_W'(ENTRIES)) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = cnt_reg[IDX_W-1:0];
                    pidx_next     = cnt_reg[IDX_W-1:0];
                    pend_next     = 1'b1;
                    cnt_next      = cnt_reg + COUNT_W'(1);
                end
                if (pend_reg) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pidx_reg;
                    ram_req.wdata = wb_entry;
                end
                if (sweep_done) begin
                    if (insert_reg) begin
                        valid_next[tgt_idx_reg] = 1'b1;
                        count_next              = count_reg + COUNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 1'b0;
            valid_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        cnt_reg      <= cnt_next;
        pidx_reg     <= pidx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_age_reg  <= hit_age_next;
        hit_val_reg  <= hit_val_next;
        vic_reg      <= vic_next;
        vic_idx_reg  <= vic_idx_next;
        vic_age_reg  <= vic_age_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        tgt_idx_reg  <= tgt_idx_next;
        limit_reg    <= limit_next;
        all_reg      <= all_next;
        insert_reg   <= insert_next;
        tval_reg     <= tval_next;
        m_found_reg  <= m_found_next;
        m_value_reg  <= m_value_next;
    end

endmodule

>>> rtl/lru_key_value_cache_unit.sv
// lru key/value cache top level; one request at a time through the entry ram
// a get result is offered once the search sweep over every slot has finished
// a new request is taken only after the previous one is finished: a get miss needs the search sweep,
// a set or a get hit also the rank update sweep, both over the single read port of the entry ram
// reset (aresetn, synchronous): valid bits and entry count cleared, capacity back to 16;
// no clearing pass, the entry ram is only read behind its valid bits
module lru_key_value_cache_unit
    import lkv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [31:0]        s_key,
    input  logic [31:0]        s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [31:0]        m_read_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [COUNT_W-1:0] eff_cap;
    ram_req_t           ram_req;
    entry_t             ram_rdata;

    lkv_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .eff_cap (eff_cap)
    );

    lkv_entry_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    lkv_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_read_value (m_read_value),
        .eff_cap      (eff_cap),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata)
    );

endmodule

>>> tb/testbench.sv
// testbench for lru_key_value_cache_unit: directed and random get/set traffic checked
// against a shadow lru store held in a small scoreboard class
// depends on lkv_pkg and the rtl top level only

typedef struct {
    logic [31:0] key;
    logic        found;
    logic [31:0] value;
} lookup_t;

class lru_shadow;
    logic [lkv_pkg::KEY_W-1:0] keys [lkv_pkg::ENTRIES];
    logic [31:0]               vals [lkv_pkg::ENTRIES];
    bit                        valid [lkv_pkg::ENTRIES];
    int unsigned               rank [lkv_pkg::ENTRIES];
    int unsigned               fill;
    logic [4:0]                capacity;
    lookup_t                   pending [$];
    int unsigned               faults;

    function new();
        capacity = lkv_pkg::CAP_RESET;
        fill = 0;
        faults = 0;
        foreach (valid[i]) begin
            valid[i] = 1'b0;
            rank[i] = 0;
            keys[i] = '0;
            vals[i] = '0;
        end
    endfunction

    function void set_capacity(logic [4:0] c);
        capacity = c;
    endfunction

    // zero acts as one, anything past the table size saturates
    function int unsigned usable();
        int unsigned c;
        c = capacity;
        if (c == 0)
            c = 1;
        if (c > lkv_pkg::ENTRIES)
            c = lkv_pkg::ENTRIES;
        return c;
    endfunction

    function void make_recent(int s, int unsigned limit);
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (valid[i] && i != s && rank[i] < limit)
                rank[i]++;
        rank[s] = 0;
    endfunction

    function int slot_of(logic [lkv_pkg::KEY_W-1:0] k);
        for (int i = 0; i < lkv_pkg::ENTRIES; i++)
            if (valid[i] && keys[i] == k)
                return i;
        return -1;
    endfunction

    function void flag(string msg);
        faults++;
        if (faults <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    function void note_request(logic cmd, logic [31:0] key, logic [31:0] value);
        int s;
        int victim;
        logic [lkv_pkg::KEY_W-1:0] k;
        lookup_t a;
        k = key[lkv_pkg::KEY_W-1:0];
        s = slot_of(k);
        if (cmd == lkv_pkg::CMD_GET) begin
            a.key = key;
            a.found = (s >= 0);
            a.value = (s >= 0) ? vals[s] : 32'h0;
            if (s >= 0)
                make_recent(s, rank[s]);
            pending.push_back(a);
            return;
        end
        if (s >= 0) begin
            vals[s] = value;
            make_recent(s, rank[s]);
            return;
        end
        if (fill >= usable()) begin
            // full, or capacity lowered under the count: reuse the oldest slot
            victim = -1;
            for (int i = 0; i < lkv_pkg::ENTRIES; i++)
                if (valid[i] && (victim < 0 || rank[i] > rank[victim]))
                    victim = i;
            if (victim >= 0) begin
                keys[victim] = k;
                vals[victim] = value;
                make_recent(victim, rank[victim]);
                return;
            end
        end
        for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
            if (!valid[i]) begin
                valid[i] = 1'b1;
                keys[i] = k;
                vals[i] = value;
                make_recent(i, 32'hFFFF_FFFF);
                fill++;
                return;
            end
        end
    endfunction

    function void check_answer(logic found, logic [31:0] value);
        lookup_t a;
        if (pending.size() == 0) begin
            flag($sformatf("result beat with no get waiting (found %0d value %h)",
                           found, value));
            return;
        end
        a = pending.pop_front();
        if (found !== a.found)
            flag($sformatf("get %h: found expected %0d got %0d", a.key, a.found, found));
        if (value !== a.value)
            flag($sformatf("get %h: read_value expected %h got %h", a.key, a.value, value));
    endfunction
endclass

module testbench;
    import lkv_pkg::*;

    localparam int SETTLE = 2 * ENTRIES + 16;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_command = CMD_GET;
    logic [31:0]        s_key = '0;
    logic [31:0]        s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic [31:0]        m_read_value;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lru_shadow    sb = new();
    logic [31:0]  key_pool [$];
    int unsigned  sent = 0;
    bit           s_steady = 1'b0;

    lru_key_value_cache_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_read_value (m_read_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // called just after a falling edge, returns just after one
    task automatic send_request(input logic cmd, input logic [31:0] key,
                                input logic [31:0] value);
        int gap;
        if (sent % 40 == 0)
            s_steady = ($urandom_range(0, 3) == 0);
        gap = s_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_key <= key;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_request(cmd, key, value);
        sent++;
        @(negedge aclk);
    endtask

    // holds the request port quiet until every get has answered and any trailing set has finished
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic program_capacity(input logic [4:0] cap);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_CAPACITY, 2'b00};
        pwdata <= PDATA_W'(cap);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        sb.set_capacity(cap);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic run_phase(input logic [4:0] cap, input int count);
        int unsigned span;
        logic cmd;
        logic [31:0] key;
        program_capacity(cap);
        // pool a little larger than the capacity so hits and evictions both happen
        key_pool.delete();
        span = sb.usable() + $urandom_range(1, sb.usable() + 4);
        if ($urandom_range(0, 1) == 1) begin
            key_pool.push_back(32'h0);
            key_pool.push_back(32'hFFFF_FFFF);
        end
        repeat (span) key_pool.push_back($urandom);
        repeat (count) begin
            cmd = ($urandom_range(0, 99) < 55) ? CMD_SET : CMD_GET;
            key = ($urandom_range(0, 9) == 0) ? $urandom
                                               : key_pool[$urandom_range(0, key_pool.size() - 1)];
            send_request(cmd, key, $urandom);
        end
        drain();
    endtask

    initial begin
        logic [4:0] caps [10];
        caps = '{5'd16, 5'd2, 5'd31, 5'd3, 5'd0, 5'd9, 5'd1, 5'd16, 5'd4, 5'd12};
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty lookup, key and value extremes, update, ignored get value
        send_request(CMD_GET, 32'h1234_5678, 32'h0);
        send_request(CMD_SET, 32'h0, 32'hFFFF_FFFF);
        send_request(CMD_SET, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_SET, 32'hAAAA_AAAA, 32'h5555_5555);
        send_request(CMD_GET, 32'h0, 32'h0);
        send_request(CMD_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(CMD_SET, 32'h0, 32'h0000_0001);
        send_request(CMD_GET, 32'h0, 32'h0);
        send_request(CMD_GET, 32'h5555_5555, 32'h0);
        send_request(CMD_GET, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
        drain();

        // capacity one while three entries are held, then capacity zero
        program_capacity(5'd1);
        send_request(CMD_SET, 32'h0000_0011, 32'hCAFE_0001);
        send_request(CMD_SET, 32'h0000_0022, 32'hCAFE_0002);
        send_request(CMD_GET, 32'h0000_0011, 32'h0);
        send_request(CMD_GET, 32'h0000_0022, 32'h0);
        drain();
        program_capacity(5'd0);
        send_request(CMD_SET, 32'h0000_0033, 32'hCAFE_0003);
        send_request(CMD_GET, 32'h0000_0022, 32'h0);
        send_request(CMD_GET, 32'h0000_0033, 32'h0);
        drain();

        foreach (caps[i])
            run_phase(caps[i], 153);

        if (sb.pending.size() != 0)
            sb.flag($sformatf("%0d get results never arrived", sb.pending.size()));
        if (sb.faults == 0)
            $display("** lru_key_value_cache_unit: PASSED **");
        else
            $display("** lru_key_value_cache_unit: FAILED **");
        $finish;
    end

    // result side: random stalls, with quiet stretches where ready stays high
    initial begin
        int n;
        int unsigned got;
        bit m_steady;
        got = 0;
        m_steady = 1'b0;
        @(negedge aclk);
        forever begin
            if (got % 32 == 0)
                m_steady = ($urandom_range(0, 3) == 0);
            n = m_steady ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
            sb.check_answer(m_found, m_read_value);
            got++;
            @(negedge aclk);
        end
    end

    initial begin
        #6_000_000;
        $display("** lru_key_value_cache_unit: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/lkv_pkg.sv
rtl/lkv_entry_ram.sv
rtl/lkv_apb_regs.sv
rtl/lkv_engine.sv
rtl/lru_key_value_cache_unit.sv
tb/testbench.sv
